>>> hw/rtl/rct_pkg.sv
// rct_pkg: shared constants for the resource claim table.
// Operation and status codes, field widths and parameter defaults.
// No dependencies.
`default_nettype none

package rct_pkg;

    // parameter defaults
    localparam int MAX_CLAIMS_DEF = 16;
    localparam int TYPE_BITS_DEF  = 4;
    localparam int OWNER_BITS_DEF = 8;

    // port field widths
    localparam int OP_W     = 2;
    localparam int TYPE_IN_W = 4;
    localparam int ID_W     = 32;
    localparam int OWNER_IN_W = 8;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLAIM   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/resource_claim_table.sv
// resource_claim_table: top level of the hardware semaphore ownership table.
// Depends on rct_pkg and rct_cell.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) takes one request word:
//    operation, resource type, resource id and owner. Output channel
//    (o_out_valid / i_out_stall) returns one word per request: status and
//    the held flag (held is set only for a query of a claimed resource).
//  - One request is worked at a time. A request token walks the row of
//    MAX_CLAIMS cells, one cell per cycle, picking up the first live match
//    and the last live entry. At the tail the result is formed and the
//    table is updated in the same cycle.
//  - The request passes r_start and the MAX_CLAIMS cell registers to the
//    tail. The next request is taken the cycle after the result is formed.
//    The length of the cell chain sets the latency.
//  - The result sits in an output register; a new request is accepted while
//    it waits. If the receiver still stalls when the next search reaches
//    the tail, the block holds there until the output register frees up.
//  - Reset (synchronous, active low) empties the table (live count zero)
//    and drops any pending result. Slot contents are not cleared; only
//    slots below the live count are ever looked at.
`default_nettype none

module resource_claim_table
    import rct_pkg::*;
#(
    parameter int MAX_CLAIMS = MAX_CLAIMS_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [TYPE_IN_W-1:0]  i_res_type,
    input  wire logic [ID_W-1:0]       i_res_id,
    input  wire logic [OWNER_IN_W-1:0] i_owner,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic                       o_held
);

    localparam int IDX_W   = (MAX_CLAIMS > 1) ? $clog2(MAX_CLAIMS) : 1;
    localparam int CNT_W   = $clog2(MAX_CLAIMS + 1);
    localparam int KEY_W   = TYPE_BITS + ID_W;
    localparam int ENT_W   = KEY_W + OWNER_BITS;
    localparam int TYPE_XW = (TYPE_BITS > TYPE_IN_W) ? TYPE_BITS : TYPE_IN_W;
    localparam int OWN_XW  = (OWNER_BITS > OWNER_IN_W) ? OWNER_BITS : OWNER_IN_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_CLAIMS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic                  r_start;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [OP_W-1:0]       r_op;
    logic [KEY_W-1:0]      r_key;
    logic [OWNER_BITS-1:0] r_own;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_held, n_held;

    // chain taps: element 0 is the head, element MAX_CLAIMS the tail
    logic [MAX_CLAIMS:0]   c_go;
    logic [MAX_CLAIMS:0]   c_hit;
    logic [IDX_W-1:0]      c_idx  [0:MAX_CLAIMS];
    logic [OWNER_BITS-1:0] c_own  [0:MAX_CLAIMS];
    logic [ENT_W-1:0]      c_last [0:MAX_CLAIMS];

    logic [TYPE_XW-1:0]    type_x;
    logic [OWN_XW-1:0]     own_x;
    logic                  accept;
    logic                  out_free;
    logic                  finish;
    logic                  own_null;
    logic                  own_match;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [ENT_W-1:0]      wr_ent;

    // only the low TYPE_BITS / OWNER_BITS of the port fields count
    assign type_x = TYPE_XW'(i_res_type);
    assign own_x  = OWN_XW'(i_owner);

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // result is formed when the token reaches the tail and the output register is free, or later from HOLD
    assign finish = out_free && ((r_state == S_SCAN && c_go[MAX_CLAIMS]) || r_state == S_HOLD);

    assign own_null  = (r_own == '0);
    assign own_match = (c_own[MAX_CLAIMS] == r_own);

    assign c_go[0]   = r_start;
    assign c_hit[0]  = 1'b0;
    assign c_idx[0]  = '0;
    assign c_own[0]  = '0;
    assign c_last[0] = '0;

    for (genvar g = 0; g < MAX_CLAIMS; g++) begin : g_cell
        rct_cell #(
            .IDX        (g),
            .MAX_CLAIMS (MAX_CLAIMS),
            .TYPE_BITS  (TYPE_BITS),
            .OWNER_BITS (OWNER_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_count   (r_count),
            .i_key     (r_key),
            .i_wr_en   (wr_en),
            .i_wr_idx  (wr_idx),
            .i_wr_ent  (wr_ent),
            .i_go      (c_go[g]),
            .i_hit     (c_hit[g]),
            .i_hit_idx (c_idx[g]),
            .i_hit_own (c_own[g]),
            .i_last    (c_last[g]),
            .o_go      (c_go[g+1]),
            .o_hit     (c_hit[g+1]),
            .o_hit_idx (c_idx[g+1]),
            .o_hit_own (c_own[g+1]),
            .o_last    (c_last[g+1])
        );
    end

    // decision at the tail: status, held flag, table write and count update
    always_comb begin
        n_status = r_status;
        n_held   = r_held;
        n_count  = r_count;
        wr_en    = 1'b0;
        wr_idx   = c_idx[MAX_CLAIMS];
        wr_ent   = c_last[MAX_CLAIMS];
        if (finish) begin
            n_status = ST_OK;
            n_held   = 1'b0;
            unique case (r_op)
                OP_CLAIM: begin
                    if (own_null) begin
                        n_status = ST_INVALID;
                    end else if (c_hit[MAX_CLAIMS]) begin
                        n_status = own_match ? ST_OK : ST_BUSY;
                    end else if (r_count >= FULL) begin
                        n_status = ST_EXHAUSTED;
                    end else begin
                        // append after the last live entry
                        wr_en   = 1'b1;
                        wr_idx  = r_count[IDX_W-1:0];
                        wr_ent  = {r_key, r_own};
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_RELEASE: begin
                    if (!own_null && c_hit[MAX_CLAIMS] && own_match) begin
                        // last live entry fills the freed slot
                        wr_en   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_INVALID;
                    end
                end
                OP_QUERY: begin
                    n_held = c_hit[MAX_CLAIMS];
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_status = ST_INVALID;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (c_go[MAX_CLAIMS]) begin
                    n_state = finish ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= accept;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_key <= {type_x[TYPE_BITS-1:0], i_res_id};
            r_own <= own_x[OWNER_BITS-1:0];
        end
        r_status <= n_status;
        r_held   <= n_held;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_held      = r_held;

endmodule

`default_nettype wire

>>> hw/rtl/rct_cell.sv
// rct_cell: one slot of the claim table plus one stage of the search chain.
// Holds a {type, id, owner} entry and forwards the search token to its neighbor.
// Depends on rct_pkg.
`default_nettype none

module rct_cell
    import rct_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int MAX_CLAIMS = MAX_CLAIMS_DEF,
    parameter int TYPE_BITS  = TYPE_BITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF,
    localparam int IDX_W = (MAX_CLAIMS > 1) ? $clog2(MAX_CLAIMS) : 1,
    localparam int CNT_W = $clog2(MAX_CLAIMS + 1),
    localparam int KEY_W = TYPE_BITS + ID_W,
    localparam int ENT_W = KEY_W + OWNER_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire logic [KEY_W-1:0]      i_key,
    input  wire logic                  i_wr_en,
    input  wire logic [IDX_W-1:0]      i_wr_idx,
    input  wire logic [ENT_W-1:0]      i_wr_ent,
    input  wire logic                  i_go,
    input  wire logic                  i_hit,
    input  wire logic [IDX_W-1:0]      i_hit_idx,
    input  wire logic [OWNER_BITS-1:0] i_hit_own,
    input  wire logic [ENT_W-1:0]      i_last,
    output logic                       o_go,
    output logic                       o_hit,
    output logic [IDX_W-1:0]           o_hit_idx,
    output logic [OWNER_BITS-1:0]      o_hit_own,
    output logic [ENT_W-1:0]           o_last
);

    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);
    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);

    logic [ENT_W-1:0] r_ent;
    logic             hit_here;

    // first live match along the chain wins
    assign hit_here = (MY_POS < i_count) && !i_hit && (r_ent[ENT_W-1:OWNER_BITS] == i_key);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_ent <= i_wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_go <= 1'b0;
        end else begin
            o_go <= i_go;
        end
    end

    // token payload moves only with the go pulse, so the tail holds it afterward
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            o_hit     <= i_hit | hit_here;
            o_hit_idx <= hit_here ? MY_IDX : i_hit_idx;
            o_hit_own <= hit_here ? r_ent[OWNER_BITS-1:0] : i_hit_own;
            o_last    <= (MY_NEXT == i_count) ? r_ent : i_last;
        end
    end

endmodule

`default_nettype wire
